// ===== hw/rtl/output_override_mask_combiner_macros.svh =====
// ----------------------------------------------------------------------------
// Output override mask combiner: assertion macros
// Concurrent assertion wrappers used by the controller (omc_ctrl.sv).
// ----------------------------------------------------------------------------
`ifndef OUTPUT_OVERRIDE_MASK_COMBINER_MACROS_SVH
`define OUTPUT_OVERRIDE_MASK_COMBINER_MACROS_SVH

// same-cycle implication, disabled during reset
`define OMC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define OMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/omc_pkg.sv =====
// ----------------------------------------------------------------------------
// Output override mask combiner package
// Shared types, opcodes, status codes and sizing constants.
// ----------------------------------------------------------------------------
package omc_pkg;

    localparam int PROFILE_SLOTS = 16;
    localparam int ENABLE_SLOTS  = 8;
    localparam int WALK_STEPS    = PROFILE_SLOTS + ENABLE_SLOTS;
    localparam int STEP_W        = $clog2(WALK_STEPS);
    localparam int PIDX_W        = $clog2(PROFILE_SLOTS);
    localparam int EIDX_W        = $clog2(ENABLE_SLOTS);

    localparam int DEF_USER_PROFILES  = 8;
    localparam int DEF_ALL_PROFILES   = 16;
    localparam int DEF_ENABLE_SOURCES = 8;

    localparam logic [31:0] FULL_WORD = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        OP_SET_DISCRETE   = 3'd0,
        OP_SET_PROFILE    = 3'd1,
        OP_TOGGLE_PROFILE = 3'd2,
        OP_WRITE_PROFILE  = 3'd3,
        OP_WRITE_ENABLE   = 3'd4,
        OP_QUERY          = 3'd5
    } t_op;

    localparam logic [1:0] STAT_DISABLED = 2'd0;
    localparam logic [1:0] STAT_FORCED   = 2'd1;
    localparam logic [1:0] STAT_AUTO_ON  = 2'd2;
    localparam logic [1:0] STAT_AUTO_OFF = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]  operation;
        logic [4:0]  output_index;
        logic [3:0]  profile_index;
        logic [2:0]  enable_index;
        logic        bit_value;
        logic [31:0] mask_word;
    } t_in_req;

    typedef struct packed {
        logic [31:0] output_word;
        logic [31:0] forced_word;
        logic [31:0] disabled_word;
        logic [1:0]  output_status;
    } t_out_rsp;

    typedef struct packed {
        logic              apply;
        logic              walk;
        logic [STEP_W-1:0] step;
        logic              publish;
    } t_cmd;

endpackage

// ===== hw/rtl/omc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Output override mask combiner: controller
// Sequences request intake, the mask walk and result hand-off.
// ----------------------------------------------------------------------------
`include "output_override_mask_combiner_macros.svh"

module omc_ctrl
    import omc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd
);

    localparam logic [STEP_W-1:0] LastStep = STEP_W'(WALK_STEPS - 1);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              w_accept;
    logic              w_out_free;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (w_accept) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                n_step = r_step + STEP_W'(1);
                if (r_step == LastStep) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall    = (r_state != S_IDLE);
        o_cmd.apply   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.walk    = (r_state == S_WALK);
        o_cmd.step    = r_step;
        o_cmd.publish = (r_state == S_DONE) && w_out_free;
        n_out_valid   = o_cmd.publish || (r_out_valid && i_out_stall);
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    `OMC_ASSERT_NEXT(a_accept_starts_walk, i_clk, i_rst_n, w_accept, (r_state == S_WALK) && (r_step == '0), "accepted request did not start the walk at step zero")
    `OMC_ASSERT_NEXT(a_walk_ends_done, i_clk, i_rst_n, (r_state == S_WALK) && (r_step == LastStep), r_state == S_DONE, "walk did not finish after the last step")
    `OMC_ASSERT_NOW(a_valid_from_done, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_DONE, "result shown without a finished walk")

endmodule

// ===== hw/rtl/omc_datapath.sv =====
// ----------------------------------------------------------------------------
// Output override mask combiner: datapath
// Holds the source state, walks the masks one per cycle and forms results.
// ----------------------------------------------------------------------------
module omc_datapath
    import omc_pkg::*;
#(
    parameter int USER_PROFILES  = DEF_USER_PROFILES,
    parameter int ALL_PROFILES   = DEF_ALL_PROFILES,
    parameter int ENABLE_SOURCES = DEF_ENABLE_SOURCES
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cmd     i_cmd,
    input  t_in_req  i_req,
    output t_out_rsp o_rsp
);

    localparam int AllLim  = (ALL_PROFILES > PROFILE_SLOTS) ? PROFILE_SLOTS : ALL_PROFILES;
    localparam int UserLim = (USER_PROFILES > AllLim) ? AllLim : USER_PROFILES;
    localparam int EnLim   = (ENABLE_SOURCES > ENABLE_SLOTS) ? ENABLE_SLOTS : ENABLE_SOURCES;

    localparam logic [PIDX_W:0] UserLimW = (PIDX_W + 1)'(UserLim);
    localparam logic [PIDX_W:0] AllLimW  = (PIDX_W + 1)'(AllLim);
    localparam logic [EIDX_W:0] EnLimW   = (EIDX_W + 1)'(EnLim);

    logic [31:0]              r_discrete;
    logic [PROFILE_SLOTS-1:0] r_active;
    logic [31:0]              r_pmask [PROFILE_SLOTS];
    logic [31:0]              r_emask [ENABLE_SLOTS];

    logic [4:0]  r_oidx;
    logic [31:0] r_acc_user;
    logic [31:0] r_acc_forced;
    logic [31:0] r_acc_en;
    t_out_rsp    r_rsp;

    logic [PIDX_W-1:0] w_pidx;
    logic [EIDX_W-1:0] w_eidx;
    logic              w_on_profiles;
    logic              w_is_user;
    logic              w_is_system;
    logic              w_en_used;
    logic [31:0]       w_pm;
    logic [31:0]       w_word;
    logic [31:0]       w_disabled;
    logic [1:0]        w_status;
    t_out_rsp          n_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_discrete <= '0;
            r_active   <= '0;
            for (int i = 0; i < PROFILE_SLOTS; i++) begin
                r_pmask[i] <= '0;
            end
            for (int i = 0; i < ENABLE_SLOTS; i++) begin
                r_emask[i] <= FULL_WORD;
            end
        end else if (i_cmd.apply) begin
            unique case (t_op'(i_req.operation))
                OP_SET_DISCRETE: begin
                    r_discrete[i_req.output_index] <= i_req.bit_value;
                end
                OP_SET_PROFILE: begin
                    r_active[i_req.profile_index] <= i_req.bit_value;
                end
                OP_TOGGLE_PROFILE: begin
                    r_active[i_req.profile_index] <= ~r_active[i_req.profile_index];
                end
                OP_WRITE_PROFILE: begin
                    r_pmask[i_req.profile_index] <= i_req.mask_word;
                end
                OP_WRITE_ENABLE: begin
                    if ({1'b0, i_req.enable_index} < EnLimW) begin
                        r_emask[i_req.enable_index] <= i_req.mask_word;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign w_on_profiles = (i_cmd.step < STEP_W'(PROFILE_SLOTS));
    assign w_pidx        = i_cmd.step[PIDX_W-1:0];
    assign w_eidx        = i_cmd.step[EIDX_W-1:0];
    assign w_pm          = r_pmask[w_pidx];
    assign w_is_user     = r_active[w_pidx] && ({1'b0, w_pidx} < UserLimW);
    assign w_is_system   = r_active[w_pidx] && ({1'b0, w_pidx} >= UserLimW)
                           && ({1'b0, w_pidx} < AllLimW);
    assign w_en_used     = ({1'b0, w_eidx} < EnLimW);

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_oidx       <= i_req.output_index;
            r_acc_user   <= '0;
            r_acc_forced <= '0;
            r_acc_en     <= FULL_WORD;
        end else if (i_cmd.walk) begin
            if (w_on_profiles) begin
                if (w_is_user) begin
                    r_acc_user <= r_acc_user | w_pm;
                end
                if (w_is_system) begin
                    r_acc_forced <= r_acc_forced | w_pm;
                end
            end else if (w_en_used) begin
                r_acc_en <= r_acc_en & r_emask[w_eidx];
            end
        end
        if (i_cmd.publish) begin
            r_rsp <= n_rsp;
        end
    end

    always_comb begin
        w_word     = (r_discrete | r_acc_user | r_acc_forced) & r_acc_en;
        w_disabled = ~r_acc_en;
        if (w_disabled[r_oidx]) begin
            w_status = STAT_DISABLED;
        end else if (r_acc_forced[r_oidx]) begin
            w_status = STAT_FORCED;
        end else if (w_word[r_oidx]) begin
            w_status = STAT_AUTO_ON;
        end else begin
            w_status = STAT_AUTO_OFF;
        end
        n_rsp.output_word   = w_word;
        n_rsp.forced_word   = r_acc_forced;
        n_rsp.disabled_word = w_disabled;
        n_rsp.output_status = w_status;
    end

    assign o_rsp = r_rsp;

endmodule

// ===== hw/rtl/output_override_mask_combiner.sv =====
// An accepted request first applies its write, then the walk visits every profile
// and enable mask, and the result is loaded into the output register, raising o_out_valid.
// No new request is taken before that load; the mask walk reads one of the
// sixteen profile masks or eight enable masks per cycle.
// A finished result waits in the output register while stalled.
// Reset (synchronous, active low) clears discrete and profile active bits,
// zeroes the profile masks and sets every enable mask to all ones.
// ----------------------------------------------------------------------------
// Output override mask combiner
// Merges discrete bits, profile masks and enable masks into one output word.
// ----------------------------------------------------------------------------
module output_override_mask_combiner
    import omc_pkg::*;
#(
    parameter int USER_PROFILES  = DEF_USER_PROFILES,
    parameter int ALL_PROFILES   = DEF_ALL_PROFILES,
    parameter int ENABLE_SOURCES = DEF_ENABLE_SOURCES
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_rsp o_out_data
);

    t_cmd w_cmd;

    omc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    omc_datapath #(
        .USER_PROFILES  (USER_PROFILES),
        .ALL_PROFILES   (ALL_PROFILES),
        .ENABLE_SOURCES (ENABLE_SOURCES)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_req   (i_in_data),
        .o_rsp   (o_out_data)
    );

endmodule

// ===== test/output_override_mask_combiner_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output override mask combiner testbench
// Runs a directed table and then weighted random requests through the block.
// Both sides idle and stall at random. A built-in predictor tracks discrete
// bits, profile actives, profile masks and enable masks, and checks every
// result in order.
// ----------------------------------------------------------------------------
module output_override_mask_combiner_tb;
    import omc_pkg::*;

    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int ALL_LIM  = (DEF_ALL_PROFILES > PROFILE_SLOTS) ?
                              PROFILE_SLOTS : DEF_ALL_PROFILES;
    localparam int USER_LIM = (DEF_USER_PROFILES > ALL_LIM) ? ALL_LIM : DEF_USER_PROFILES;
    localparam int EN_LIM   = (DEF_ENABLE_SOURCES > ENABLE_SLOTS) ?
                              ENABLE_SLOTS : DEF_ENABLE_SOURCES;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 40;

    typedef struct {
        t_in_req  req;
        bit       has_lit;
        t_out_rsp lit;
    } t_dir_row;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_in_req  i_in_data   = '0;
    logic     i_out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_out_rsp o_out_data;

    logic [31:0] pred_discrete;
    logic [15:0] pred_active;
    logic [31:0] pred_profile_mask [PROFILE_SLOTS];
    logic [31:0] pred_enable_mask [ENABLE_SLOTS];

    t_out_rsp    pending_words [$];
    t_out_rsp    want;
    t_dir_row    directed_rows [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    bit          steady         = 1'b0;
    bit          hold_req       = 1'b0;

    output_override_mask_combiner u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    task automatic combine_outputs(input t_in_req req, output t_out_rsp rsp);
        logic [31:0] word;
        logic [31:0] forced;
        logic [31:0] enabled;
        case (req.operation)
            OP_SET_DISCRETE:   pred_discrete[req.output_index] = req.bit_value;
            OP_SET_PROFILE:    pred_active[req.profile_index] = req.bit_value;
            OP_TOGGLE_PROFILE: pred_active[req.profile_index] = ~pred_active[req.profile_index];
            OP_WRITE_PROFILE:  pred_profile_mask[req.profile_index] = req.mask_word;
            OP_WRITE_ENABLE: begin
                if (int'(req.enable_index) < DEF_ENABLE_SOURCES)
                    pred_enable_mask[req.enable_index] = req.mask_word;
            end
            default: ;
        endcase
        word    = pred_discrete;
        forced  = '0;
        enabled = FULL_WORD;
        for (int p = 0; p < ALL_LIM; p++) begin
            if (pred_active[p]) begin
                if (p < USER_LIM)
                    word |= pred_profile_mask[p];
                else
                    forced |= pred_profile_mask[p];
            end
        end
        for (int e = 0; e < EN_LIM; e++) enabled &= pred_enable_mask[e];
        word = (word | forced) & enabled;
        rsp.output_word   = word;
        rsp.forced_word   = forced;
        rsp.disabled_word = ~enabled;
        if (!enabled[req.output_index])
            rsp.output_status = STAT_DISABLED;
        else if (forced[req.output_index])
            rsp.output_status = STAT_FORCED;
        else if (word[req.output_index])
            rsp.output_status = STAT_AUTO_ON;
        else
            rsp.output_status = STAT_AUTO_OFF;
    endtask

    function automatic int unsigned idle_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] profile_pattern();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h1 << $urandom_range(0, 31);
            2: return $urandom() & $urandom();
            3: return ~(32'h1 << $urandom_range(0, 31));
            4: return 32'h0;
            default: return FULL_WORD;
        endcase
    endfunction

    function automatic logic [31:0] enable_pattern();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 6) return FULL_WORD;
        if (r < 12) return ~(32'h1 << $urandom_range(0, 31));
        if (r < 17) return ~($urandom() & $urandom() & $urandom());
        if (r == 17) return $urandom();
        if (r == 18) return 32'h0;
        return FULL_WORD;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at cycle %0d: %s expected %08h got %08h",
                     cycle_count, what, want_v, got_v);
    endtask

    task automatic add_row(input logic [2:0] op, input logic [4:0] oidx,
                           input logic [3:0] pidx, input logic [2:0] eidx,
                           input logic bitv, input logic [31:0] mask,
                           input bit has_lit = 1'b0, input t_out_rsp lit = '0);
        t_dir_row row;
        row.req.operation     = op;
        row.req.output_index  = oidx;
        row.req.profile_index = pidx;
        row.req.enable_index  = eidx;
        row.req.bit_value     = bitv;
        row.req.mask_word     = mask;
        row.has_lit           = has_lit;
        row.lit               = lit;
        directed_rows.push_back(row);
    endtask

    // Enter and leave at a falling edge.
    task automatic send_request(input t_in_req req, input bit has_lit,
                                input t_out_rsp lit);
        int unsigned idle;
        t_out_rsp    rsp;
        idle = steady ? 0 : idle_cycles();
        if (idle != 0) begin
            i_in_valid <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        combine_outputs(req, rsp);
        pending_words.push_back(has_lit ? lit : rsp);
        @(negedge i_clk);
    endtask

    task automatic run_random(input int unsigned count);
        t_in_req     req;
        int unsigned r;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 20)      req.operation = OP_SET_DISCRETE;
            else if (r < 35) req.operation = OP_SET_PROFILE;
            else if (r < 50) req.operation = OP_TOGGLE_PROFILE;
            else if (r < 70) req.operation = OP_WRITE_PROFILE;
            else if (r < 82) req.operation = OP_WRITE_ENABLE;
            else if (r < 95) req.operation = OP_QUERY;
            else if (r < 97) req.operation = OP_SPARE_6;
            else             req.operation = OP_SPARE_7;
            req.output_index  = $urandom_range(0, 31);
            req.profile_index = $urandom_range(0, 15);
            req.enable_index  = $urandom_range(0, 7);
            req.bit_value     = $urandom_range(0, 1);
            if (req.operation == OP_WRITE_ENABLE)
                req.mask_word = enable_pattern();
            else if (req.operation == OP_WRITE_PROFILE)
                req.mask_word = profile_pattern();
            else
                req.mask_word = $urandom();
            send_request(req, 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_words.size() == 0) begin
                flag_mismatch("result with no request pending, output_word", 32'h0,
                              o_out_data.output_word);
            end else begin
                want = pending_words.pop_front();
                if (o_out_data.output_word !== want.output_word)
                    flag_mismatch("output_word", want.output_word, o_out_data.output_word);
                if (o_out_data.forced_word !== want.forced_word)
                    flag_mismatch("forced_word", want.forced_word, o_out_data.forced_word);
                if (o_out_data.disabled_word !== want.disabled_word)
                    flag_mismatch("disabled_word", want.disabled_word,
                                  o_out_data.disabled_word);
                if (o_out_data.output_status !== want.output_status)
                    flag_mismatch("output_status", 32'(want.output_status),
                                  32'(o_out_data.output_status));
            end
        end
    end

    initial begin
        int unsigned span;
        bit          stall_now;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                stall_now = 1'b1;
                span      = HOLD_CYCLES;
            end else if (steady) begin
                stall_now = 1'b0;
                span      = $urandom_range(1, 20);
            end else begin
                stall_now = ($urandom_range(0, 2) == 0);
                span      = stall_now ? idle_cycles() + 1 : $urandom_range(1, 30);
            end
            i_out_stall <= stall_now;
            repeat (span - 1) @(negedge i_clk);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        pred_discrete = '0;
        pred_active   = '0;
        for (int p = 0; p < PROFILE_SLOTS; p++) pred_profile_mask[p] = '0;
        for (int e = 0; e < ENABLE_SLOTS; e++) pred_enable_mask[e] = FULL_WORD;

        add_row(OP_QUERY, 5'd0, 4'd0, 3'd0, 1'b0, 32'h0, 1'b1,
                {32'h0000_0000, 32'h0000_0000, 32'h0000_0000, STAT_AUTO_OFF});
        add_row(OP_SET_DISCRETE, 5'd31, 4'd0, 3'd0, 1'b1, 32'h0, 1'b1,
                {32'h8000_0000, 32'h0000_0000, 32'h0000_0000, STAT_AUTO_ON});
        add_row(OP_SET_DISCRETE, 5'd0, 4'd15, 3'd7, 1'b1, FULL_WORD, 1'b1,
                {32'h8000_0001, 32'h0000_0000, 32'h0000_0000, STAT_AUTO_ON});
        add_row(OP_WRITE_ENABLE, 5'd0, 4'd0, 3'd7, 1'b0, 32'h0, 1'b1,
                {32'h0000_0000, 32'h0000_0000, FULL_WORD, STAT_DISABLED});
        add_row(OP_WRITE_ENABLE, 5'd31, 4'd0, 3'd7, 1'b0, FULL_WORD, 1'b1,
                {32'h8000_0001, 32'h0000_0000, 32'h0000_0000, STAT_AUTO_ON});
        add_row(OP_WRITE_PROFILE, 5'd16, 4'd15, 3'd0, 1'b0, 32'hFFFF_0000);
        add_row(OP_SET_PROFILE, 5'd16, 4'd15, 3'd0, 1'b1, 32'h0);
        add_row(OP_WRITE_PROFILE, 5'd3, 4'd0, 3'd0, 1'b0, 32'h0000_FFFF);
        add_row(OP_TOGGLE_PROFILE, 5'd5, 4'd0, 3'd0, 1'b0, 32'h0);
        add_row(OP_WRITE_PROFILE, 5'd8, 4'd8, 3'd0, 1'b0, 32'h00F0_0F00);
        add_row(OP_SET_PROFILE, 5'd8, 4'd8, 3'd0, 1'b1, 32'h0);
        add_row(OP_WRITE_ENABLE, 5'd0, 4'd0, 3'd0, 1'b0, 32'hAAAA_AAAA);
        add_row(OP_WRITE_ENABLE, 5'd15, 4'd0, 3'd3, 1'b0, 32'hFFFF_7FFF);
        add_row(OP_SPARE_6, 5'd1, 4'd3, 3'd2, 1'b1, 32'h1234_5678);
        add_row(OP_SPARE_7, 5'd31, 4'd15, 3'd7, 1'b1, FULL_WORD);
        add_row(OP_TOGGLE_PROFILE, 5'd20, 4'd15, 3'd0, 1'b0, 32'h0);
        add_row(OP_SET_PROFILE, 5'd9, 4'd7, 3'd0, 1'b1, 32'h0);
        add_row(OP_SET_DISCRETE, 5'd31, 4'd0, 3'd0, 1'b0, 32'h0);
        add_row(OP_WRITE_PROFILE, 5'd0, 4'd7, 3'd0, 1'b0, 32'h0000_0001);
        add_row(OP_SET_PROFILE, 5'd2, 4'd0, 3'd0, 1'b0, 32'h0);
        add_row(OP_WRITE_ENABLE, 5'd1, 4'd0, 3'd0, 1'b0, FULL_WORD);
        add_row(OP_WRITE_ENABLE, 5'd15, 4'd0, 3'd3, 1'b0, FULL_WORD);
        add_row(OP_QUERY, 5'd23, 4'd0, 3'd0, 1'b0, 32'h0);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_request(directed_rows[k].req, directed_rows[k].has_lit, directed_rows[k].lit);

        run_random(500);
        steady = 1'b1;
        run_random(100);
        steady = 1'b0;

        // drain before the long receiver hold
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        @(negedge i_clk);

        hold_req = 1'b1;
        steady   = 1'b1;
        run_random(40);
        steady   = 1'b0;

        run_random(700);

        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_words.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== output_override_mask_combiner.f =====
+incdir+hw/rtl
hw/rtl/omc_pkg.sv
hw/rtl/omc_ctrl.sv
hw/rtl/omc_datapath.sv
hw/rtl/output_override_mask_combiner.sv
test/output_override_mask_combiner_tb.sv
